// ----- sv/sbrd_pkg.sv -----
package sbrd_pkg;

  localparam int MAG_W   = 24;
  localparam int FREQ_W  = 32;
  localparam int DECAY_W = 18;
  localparam int BIN_W   = 10;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = MAG_W + DECAY_W;

  localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(65536);
  localparam logic [MAG_W-1:0]   MAG_MAX     = '1;

  // one held bin: frequency above magnitude
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MAG_W-1:0]  mag;
  } held_t;

  // load of the address stage
  typedef struct packed {
    logic             load;
    logic             channel;
    logic [BIN_W-1:0] bin;
  } wrap_in_t;

endpackage

// ----- sv/sbrd_bin_wrap.sv -----
module sbrd_bin_wrap #(
  parameter int MAX_BINS     = 1024,
  parameter int NUM_CHANNELS = 2,
  localparam int AW = $clog2(NUM_CHANNELS * MAX_BINS)
) (
  input  logic               clk,
  input  sbrd_pkg::wrap_in_t wi,
  output logic [AW-1:0]      addr
);

  localparam int BIN_W = sbrd_pkg::BIN_W;
  localparam int RW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SH    = BIN_W + RW;
  localparam int MW    = BIN_W + 2;
  localparam int PW    = BIN_W + MW;
  // reciprocal of MAX_BINS, exact quotient for every BIN_W-bit bin
  localparam int RECIP = (2**SH + MAX_BINS - 1) / MAX_BINS;

  logic [PW-1:0]    prod;
  logic [BIN_W-1:0] q_next;
  logic [BIN_W-1:0] q_r;
  logic [BIN_W-1:0] bin_r;
  logic             ch_r;
  logic [BIN_W-1:0] rem;
  logic             ch_wrap;

  assign prod   = PW'(wi.bin) * PW'(RECIP);
  assign q_next = BIN_W'(prod >> SH);

  always_ff @(posedge clk) begin
    if (wi.load) begin
      q_r   <= q_next;
      bin_r <= wi.bin;
      ch_r  <= wi.channel;
    end
  end

  assign rem     = BIN_W'(int'(bin_r) - int'(q_r) * MAX_BINS);
  assign ch_wrap = (NUM_CHANNELS > 1) ? ch_r : 1'b0;
  assign addr    = AW'(rem) + (ch_wrap ? AW'(MAX_BINS) : AW'(0));

endmodule

// ----- sv/spectral_bin_resonance_decay.sv -----
// Stages: each item passes through the wrap, read, multiply and result registers in turn.
// Throughput: one item per cycle while the output is not stalled; an item for the same entry as
//   the item just ahead of it waits, because that entry's new value is not ready in time for its read.
// Reset: clears all valid flags and sets decay_factor to 65536; the held-bin memory is
//   not cleared, an entry reads undefined until its first write.
module spectral_bin_resonance_decay #(
  parameter int MAX_BINS     = 1024,
  parameter int NUM_CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  // config: decay factor, unsigned Q2.16
  input  logic        cfg_we,
  input  logic [17:0] cfg_wdata,
  // input bins
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] channel, [10:1] bin_index, [34:11] in_magnitude, [66:35] in_frequency, [71:67] zero
  input  logic [71:0] s_axis_tdata,
  // [0] first_frame, [1] has_source
  input  logic [1:0]  s_axis_tuser,
  // result bins
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] out_magnitude, [55:24] out_frequency
  output logic [55:0] m_axis_tdata,
  // [0] took_source
  output logic        m_axis_tuser
);

  localparam int MAG_W   = sbrd_pkg::MAG_W;
  localparam int FREQ_W  = sbrd_pkg::FREQ_W;
  localparam int DECAY_W = sbrd_pkg::DECAY_W;
  localparam int BIN_W   = sbrd_pkg::BIN_W;
  localparam int FRAC_W  = sbrd_pkg::FRAC_W;
  localparam int PROD_W  = sbrd_pkg::PROD_W;
  localparam int DEPTH   = NUM_CHANNELS * MAX_BINS;
  localparam int AW      = $clog2(DEPTH);

  // decay register
  logic [DECAY_W-1:0] decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay <= sbrd_pkg::DECAY_RESET;
    end else if (cfg_we) begin
      decay <= cfg_wdata;
    end
  end

  // Pipeline: s0 wraps the address, s1 holds the memory read, s2 holds the product,
  // the output register holds the result and is the last value written back.
  // Everything past s0 moves together when the output register can take a result.
  logic adv;
  logic issue;
  logic hazard;
  logic in_acc;
  logic mem_we;

  // s0
  logic              s0_valid;
  logic [MAG_W-1:0]  s0_mag;
  logic [FREQ_W-1:0] s0_freq;
  logic              s0_first;
  logic              s0_src;
  logic [AW-1:0]     s0_addr;
  sbrd_pkg::wrap_in_t wrap_in;

  // s1
  logic              s1_valid;
  logic [AW-1:0]     s1_addr;
  logic [MAG_W-1:0]  s1_mag;
  logic [FREQ_W-1:0] s1_freq;
  logic              s1_first;
  logic              s1_src;
  sbrd_pkg::held_t   rd_q;
  sbrd_pkg::held_t   s1_held;

  // s2
  logic              s2_valid;
  logic [AW-1:0]     s2_addr;
  logic [MAG_W-1:0]  s2_mag;
  logic [FREQ_W-1:0] s2_freq;
  logic              s2_first;
  logic              s2_src;
  logic [FREQ_W-1:0] s2_hfreq;
  logic [PROD_W-1:0] s2_prod;

  // result
  logic [PROD_W-FRAC_W-1:0] dec_full;
  logic [MAG_W-1:0]         dec_mag;
  logic                     take;
  logic [MAG_W-1:0]         res_mag;
  logic [FREQ_W-1:0]        res_freq;

  // output / write-back register
  logic              out_valid;
  logic [MAG_W-1:0]  out_mag;
  logic [FREQ_W-1:0] out_freq;
  logic              out_took;
  logic [AW-1:0]     wb_addr;
  logic              wb_valid;

  sbrd_pkg::held_t held_mem [DEPTH];

  assign adv    = !out_valid || m_axis_tready;
  // an item for the entry still in s1 would read before that entry is written back
  assign hazard = s1_valid && (s1_addr == s0_addr);
  assign issue  = adv && s0_valid && !hazard;
  assign s_axis_tready = !s0_valid || issue;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign mem_we = adv && s2_valid;

  assign wrap_in.load    = in_acc;
  assign wrap_in.channel = s_axis_tdata[0];
  assign wrap_in.bin     = s_axis_tdata[BIN_W:1];

  sbrd_bin_wrap #(
    .MAX_BINS     (MAX_BINS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_wrap (
    .clk  (clk),
    .wi   (wrap_in),
    .addr (s0_addr)
  );

  // s0
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_acc) begin
      s0_valid <= 1'b1;
    end else if (issue) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_mag   <= s_axis_tdata[34:11];
      s0_freq  <= s_axis_tdata[66:35];
      s0_first <= s_axis_tuser[0];
      s0_src   <= s_axis_tuser[1];
    end
  end

  // held-bin memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[s2_addr] <= '{freq: res_freq, mag: res_mag};
    end
    if (issue) begin
      rd_q <= held_mem[s0_addr];
    end
  end

  // s1: the write-back register is the newest write, so it wins on a match
  always_comb begin
    if (wb_valid && (wb_addr == s1_addr)) begin
      s1_held = '{freq: out_freq, mag: out_mag};
    end else begin
      s1_held = rd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr  <= s0_addr;
      s1_mag   <= s0_mag;
      s1_freq  <= s0_freq;
      s1_first <= s0_first;
      s1_src   <= s0_src;
    end
    if (adv) begin
      s2_addr  <= s1_addr;
      s2_mag   <= s1_mag;
      s2_freq  <= s1_freq;
      s2_first <= s1_first;
      s2_src   <= s1_src;
      s2_hfreq <= s1_held.freq;
      s2_prod  <= PROD_W'(s1_held.mag) * PROD_W'(decay);
    end
  end

  // s2: drop the fraction, saturate to 24 bits, strict compare against the source
  assign dec_full = s2_prod[PROD_W-1:FRAC_W];
  assign dec_mag  = (|dec_full[PROD_W-FRAC_W-1:MAG_W]) ? sbrd_pkg::MAG_MAX
                                                       : dec_full[MAG_W-1:0];
  assign take     = s2_first || (s2_src && (s2_mag > dec_mag));
  assign res_mag  = take ? s2_mag  : dec_mag;
  assign res_freq = take ? s2_freq : s2_hfreq;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wb_valid  <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        wb_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      out_mag  <= res_mag;
      out_freq <= res_freq;
      out_took <= take;
      wb_addr  <= s2_addr;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_freq, out_mag};
  assign m_axis_tuser  = out_took;

  // the two items in flight past the read never share an entry
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |-> (s1_addr != s2_addr))
    else $error("s1 and s2 hold the same entry");

  // a first-frame bin always comes out as taken
  a_first_taken: assert property (@(posedge clk) disable iff (rst)
    (mem_we && s2_first) |=> (m_axis_tvalid && m_axis_tuser))
    else $error("first-frame bin not taken");

  // a held read result stays put while the pipeline is stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_addr) && $stable(rd_q)))
    else $error("s1 changed during stall");

  // the decay register follows a write
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (decay == $past(cfg_wdata)))
    else $error("decay register missed a write");

endmodule

// ----- tb/sv/tb_spectral_bin_resonance_decay.sv -----
`timescale 1ns / 100ps

module tb_spectral_bin_resonance_decay;

  localparam int MAX_BINS     = 1024;
  localparam int NUM_CHANNELS = 2;
  localparam int DEPTH        = MAX_BINS * NUM_CHANNELS;
  localparam int MAG_W        = sbrd_pkg::MAG_W;
  localparam int FREQ_W       = sbrd_pkg::FREQ_W;
  localparam int DECAY_W      = sbrd_pkg::DECAY_W;
  localparam int BIN_W        = sbrd_pkg::BIN_W;
  localparam int FRAC_W       = sbrd_pkg::FRAC_W;
  localparam int PROD_W       = sbrd_pkg::PROD_W;
  // spare cycles waited after the last result
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // one input bin as the block sees it
  typedef struct packed {
    logic              channel;
    logic [BIN_W-1:0]  bin;
    logic [MAG_W-1:0]  mag;
    logic [FREQ_W-1:0] freq;
    logic              first;
    logic              src;
  } bin_item_t;

  // one result bin
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [FREQ_W-1:0] freq;
    logic              took;
  } bin_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [17:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  spectral_bin_resonance_decay #(
    .MAX_BINS(MAX_BINS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // decay factor as the block currently holds it
  logic [DECAY_W-1:0] decay_now = sbrd_pkg::DECAY_RESET;

  // predictor store, advanced at acceptance
  sbrd_pkg::held_t held_track [DEPTH];
  // generator's shadow store, advanced as items are queued; lets the stimulus
  // aim magnitudes at the decayed value and avoid reading unwritten entries
  sbrd_pkg::held_t held_shadow [DEPTH];
  bit    shadow_written [DEPTH];
  int    written_entries [$];
  int    last_entry = -1;

  bin_item_t   pending_bins [$];
  bin_result_t expected_out [$];

  int errors = 0;
  int results_seen = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  // decay, saturate, then pick source or held bin
  function automatic bin_result_t resolve_bin(sbrd_pkg::held_t held, bin_item_t it,
                                               logic [DECAY_W-1:0] factor);
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-FRAC_W-1:0] scaled;
    logic [MAG_W-1:0]         decayed;
    bin_result_t              r;
    prod    = PROD_W'(held.mag) * PROD_W'(factor);
    scaled  = prod[PROD_W-1:FRAC_W];
    decayed = (|scaled[PROD_W-FRAC_W-1:MAG_W]) ? sbrd_pkg::MAG_MAX : scaled[MAG_W-1:0];
    // equal magnitude keeps the held bin; first frame ignores has_source
    if (it.first || (it.src && it.mag > decayed))
      r = '{mag: it.mag, freq: it.freq, took: 1'b1};
    else
      r = '{mag: decayed, freq: held.freq, took: 1'b0};
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("t=%0t %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // queue one item and advance the shadow store
  task automatic queue_bin(logic ch, logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag,
                           logic [FREQ_W-1:0] freq, logic first, logic src);
    bin_item_t   it;
    bin_result_t r;
    int          e;
    it = '{channel: ch, bin: bin, mag: mag, freq: freq, first: first, src: src};
    e  = int'({ch, bin});
    r  = resolve_bin(held_shadow[e], it, decay_now);
    held_shadow[e] = '{freq: r.freq, mag: r.mag};
    if (!shadow_written[e]) begin
      shadow_written[e] = 1'b1;
      written_entries.push_back(e);
    end
    last_entry = e;
    pending_bins.push_back(it);
  endtask

  // mostly later-frame bins on entries already written, with magnitudes near
  // the decayed value so the strict compare gets exercised
  task automatic queue_random_bin();
    int               e;
    int               pick;
    bin_item_t        probe;
    bin_result_t      kept;
    logic [MAG_W-1:0] d;
    logic [MAG_W-1:0] m;
    pick = $urandom_range(0, 99);
    if (written_entries.size() == 0 || pick < 15) begin
      if ($urandom_range(0, 9) < 7)
        e = $urandom_range(0, NUM_CHANNELS - 1) * MAX_BINS + $urandom_range(0, 7);
      else
        e = $urandom_range(0, DEPTH - 1);
      queue_bin(e[10], e[9:0], MAG_W'($urandom), $urandom, 1'b1, 1'($urandom_range(0, 1)));
    end else begin
      if (last_entry >= 0 && $urandom_range(0, 9) < 3)
        e = last_entry;
      else
        e = written_entries[$urandom_range(0, written_entries.size() - 1)];
      probe = '{channel: e[10], bin: e[9:0], mag: '0, freq: '0, first: 1'b0, src: 1'b0};
      kept  = resolve_bin(held_shadow[e], probe, decay_now);
      d     = kept.mag;
      case ($urandom_range(0, 6))
        0: m = d;
        1: m = (d == sbrd_pkg::MAG_MAX) ? d : d + 1'b1;
        2: m = (d == '0) ? d : d - 1'b1;
        3: m = MAG_W'($urandom);
        4: m = MAG_W'($urandom_range(0, 255));
        5: m = '0;
        default: m = sbrd_pkg::MAG_MAX;
      endcase
      queue_bin(e[10], e[9:0], m, $urandom, 1'b0, 1'($urandom_range(0, 3) != 0));
    end
  endtask

  // only while idle: nothing pending, nothing in flight
  task automatic set_decay(logic [DECAY_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    decay_now = v;
  endtask

  // wait until every queued bin is sent and every expected result has come
  task automatic drain();
    while (pending_bins.size() != 0 || s_axis_tvalid || expected_out.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps; tvalid holds while
  // stalled, and prediction happens on the accepting edge.
  // -------------------------------------------------------------------------
  bin_item_t cur_item;
  int        burst_left = 1;
  int        gap_left = 0;

  always @(posedge clk) begin
    bin_result_t r;
    bit          offer;
    int          e;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        e = int'({cur_item.channel, cur_item.bin});
        r = resolve_bin(held_track[e], cur_item, decay_now);
        held_track[e] = '{freq: r.freq, mag: r.mag};
        expected_out.push_back(r);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bins.size() != 0) begin
          cur_item = pending_bins.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // zero gaps now and then give stretches with no idling
            gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                       ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) :
                       $urandom_range(1, 5);
          end
        end
        s_axis_tvalid <= offer;
        if (offer) begin
          s_axis_tdata <= {5'b0, cur_item.freq, cur_item.mag, cur_item.bin,
                           cur_item.channel};
          s_axis_tuser <= {cur_item.src, cur_item.first};
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation;
  // tready follows a stall pattern whose mode is periodically re-picked at random.
  // -------------------------------------------------------------------------
  int stall_cnt = 0;
  int stall_mode = 0;

  always @(posedge clk) begin
    bin_result_t want;
    bit          rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          report_mismatch("result with none expected", longint'(m_axis_tdata), 0);
        end else begin
          want = expected_out.pop_front();
          if (m_axis_tdata[23:0] !== want.mag)
            report_mismatch("out_magnitude", longint'(m_axis_tdata[23:0]),
                            longint'(want.mag));
          if (m_axis_tdata[55:24] !== want.freq)
            report_mismatch("out_frequency", longint'(m_axis_tdata[55:24]),
                            longint'(want.freq));
          if (m_axis_tuser !== want.took)
            report_mismatch("took_source", longint'(m_axis_tuser), longint'(want.took));
        end
      end
      stall_cnt++;
      if (stall_cnt % 64 == 0)
        stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 9) != 0);
        default: rdy = (stall_cnt % 3 == 0);
      endcase
      m_axis_tready <= rdy && !hold_off;
    end
  end

  // long receiver hold-off while the sender keeps offering: fills the
  // pipeline and pushes back on the input
  initial begin
    while (results_seen < 100) @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
    while (results_seen < 500) @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("spectral_bin_resonance_decay: mismatch");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus: directed bins at the reset decay factor, then random phases
  // across decay settings including both extremes of the register.
  // -------------------------------------------------------------------------
  initial begin
    logic [DECAY_W-1:0] factors [8];
    factors = '{18'd0, 18'h3FFFF, 18'd131072, 18'd65535, 18'd1, 18'd0, 18'd0, 18'd0};
    for (int i = 5; i < 8; i++)
      factors[i] = DECAY_W'($urandom_range(0, 18'h3FFFF));

    // first frame copies through whatever has_source says
    queue_bin(1'b0, 10'd0, 24'd0, 32'd0, 1'b1, 1'b0);
    queue_bin(1'b1, 10'd1023, sbrd_pkg::MAG_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // equal magnitude keeps the held bin, one louder takes over
    queue_bin(1'b0, 10'd0, 24'd0, 32'd123, 1'b0, 1'b1);
    queue_bin(1'b0, 10'd0, 24'd1, 32'h5555_AAAA, 1'b0, 1'b1);
    // tail bins: no source, or a source that is not louder; decayed bin kept
    queue_bin(1'b1, 10'd1023, sbrd_pkg::MAG_MAX, 32'd0, 1'b0, 1'b0);
    queue_bin(1'b1, 10'd1023, sbrd_pkg::MAG_MAX, 32'd0, 1'b0, 1'b1);
    queue_bin(1'b1, 10'd1023, sbrd_pkg::MAG_MAX - 1'b1, 32'd0, 1'b0, 1'b1);
    // consecutive bins on one entry
    queue_bin(1'b0, 10'd512, 24'h80_0000, 32'h8000_0000, 1'b1, 1'b1);
    queue_bin(1'b0, 10'd512, 24'h80_0001, 32'd1, 1'b0, 1'b1);
    queue_bin(1'b0, 10'd512, 24'h80_0001, 32'd2, 1'b0, 1'b1);
    queue_bin(1'b0, 10'd512, 24'h80_0002, 32'd3, 1'b0, 1'b0);
    // alternating bit patterns
    queue_bin(1'b1, 10'd341, 24'h55_5555, 32'hAAAA_5555, 1'b1, 1'b0);
    queue_bin(1'b0, 10'd682, 24'hAA_AAAA, 32'h5555_AAAA, 1'b1, 1'b1);
    queue_bin(1'b1, 10'd341, 24'hAA_AAAA, 32'd7, 1'b0, 1'b1);
    queue_bin(1'b0, 10'd682, 24'h55_5555, 32'd8, 1'b0, 1'b1);
    // first frame over a written entry
    queue_bin(1'b0, 10'd0, 24'd0, 32'd0, 1'b1, 1'b0);
    for (int i = 0; i < 150; i++)
      queue_random_bin();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    drain();

    foreach (factors[p]) begin
      set_decay(factors[p]);
      if (p == 0) begin
        // zero factor: everything decays to nothing
        queue_bin(1'b0, 10'd512, 24'd0, 32'd9, 1'b0, 1'b1);
        queue_bin(1'b0, 10'd512, 24'd0, 32'd10, 1'b0, 1'b0);
      end else if (p == 1) begin
        // largest factor on a full-scale entry saturates
        queue_bin(1'b1, 10'd1023, sbrd_pkg::MAG_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_bin(1'b1, 10'd1023, 24'd0, 32'd0, 1'b0, 1'b0);
        queue_bin(1'b1, 10'd1023, sbrd_pkg::MAG_MAX, 32'd0, 1'b0, 1'b1);
      end
      for (int i = 0; i < 85; i++)
        queue_random_bin();
      drain();
    end

    if (errors == 0) begin
      $display("spectral_bin_resonance_decay: match");
    end else begin
      $display("spectral_bin_resonance_decay: mismatch");
    end
    $finish;
  end

endmodule
